### sv/prs_pkg.sv
// shared codes, field widths and control/status types for the peer retransmit scheduler
package prs_pkg;

    // input commands
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;
    localparam logic [1:0] CMD_REPLY   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_SEND  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_REPLY = 2'd2;
    localparam logic [1:0] KIND_ACK   = 2'd3;

    // backoff modes
    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_EXP    = 2'd1;
    localparam logic [1:0] MODE_PROG   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;
    localparam logic [1:0] CFG_MODE  = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0] RETRY_MAX = 8'hFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  peer_index;
        logic [31:0] send_addr;
        logic [4:0]  pending_count;
        logic [31:0] next_deadline;
        logic        all_done;
        logic        duplicate_reply;
        logic        table_full;
        logic        last;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic start;     // transaction accepted this cycle
        logic rd_en;     // read one table entry into the pipe
        logic sum_emit;  // load the summary into the output register
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic adv;        // pipe moves this cycle
        logic pipe_empty;
        logic out_free;
    } t_stat;

endpackage

### sv/prs_req_if.sv
// input channel: command, peer address and current time
interface prs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] peer_addr;
    logic [31:0] now;

    modport source (output valid, command, peer_addr, now, input ready);
    modport sink (input valid, command, peer_addr, now, output ready);
endinterface

### sv/prs_rsp_if.sv
// result channel: send requests, summaries and acknowledges
interface prs_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  peer_index;
    logic [31:0] send_addr;
    logic [4:0]  pending_count;
    logic [31:0] next_deadline;
    logic        all_done;
    logic        duplicate_reply;
    logic        table_full;
    logic        last;

    modport source (output valid, kind, peer_index, send_addr, pending_count, next_deadline,
                    all_done, duplicate_reply, table_full, last, input ready);
    modport sink (input valid, kind, peer_index, send_addr, pending_count, next_deadline,
                  all_done, duplicate_reply, table_full, last, output ready);
endinterface

### sv/prs_ctrl.sv
// controller: accepts a transaction, walks the peer table, then triggers the summary
module prs_ctrl #(
    parameter int MAX_PEERS = 16,
    localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1,
    localparam int CW = $clog2(MAX_PEERS + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_vld,
    output logic            o_req_rdy,
    input  prs_pkg::t_stat  i_stat,
    input  logic [CW-1:0]   i_loaded,
    output prs_pkg::t_ctl   o_ctl,
    output logic [IW-1:0]   o_rd_idx
);
    import prs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_SUM  = 2'd2;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] n_idx;

    assign o_req_rdy = (r_state == S_IDLE);
    assign o_rd_idx  = r_idx[IW-1:0];

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_vld) begin
                    o_ctl.start = 1'b1;
                    n_idx       = '0;
                    n_state     = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.adv) begin
                    if (r_idx < i_loaded) begin
                        o_ctl.rd_en = 1'b1;
                        n_idx       = CW'(r_idx + 1'b1);
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                // last entry must leave the pipe before the summary goes out
                if (i_stat.pipe_empty && i_stat.out_free) begin
                    o_ctl.sum_emit = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

### sv/prs_datapath.sv
// datapath: peer table memory, two-stage entry evaluation, accumulators and output register
module prs_datapath #(
    parameter int MAX_PEERS = 16,
    localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1,
    localparam int CW = $clog2(MAX_PEERS + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [1:0]                        i_command,
    input  logic [31:0]                       i_peer_addr,
    input  logic [31:0]                       i_now,
    input  logic                              i_cfg_we,
    input  logic [prs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [prs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  prs_pkg::t_ctl                     i_ctl,
    input  logic [IW-1:0]                     i_rd_idx,
    output prs_pkg::t_stat                    o_stat,
    output logic [CW-1:0]                     o_loaded,
    output logic                              o_rsp_vld,
    input  logic                              i_rsp_rdy,
    output prs_pkg::t_rsp                     o_rsp
);
    import prs_pkg::*;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] last_sent;
        logic [7:0]  retries;
        logic        replied;
    } t_entry;

    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PEERS);

    function automatic logic [31:0] f_backoff(input logic [15:0] base,
                                              input logic [1:0]  mode,
                                              input logic [7:0]  ret);
        logic [7:0]  sh;
        logic [47:0] shifted;
        logic [24:0] prod;
        logic [31:0] res;
        sh      = (ret > 8'd1) ? ret - 8'd1 : 8'd0;
        shifted = {32'd0, base} << sh[4:0];
        prod    = 25'(base) * 25'({1'b0, ret} + 9'd1);
        case (mode)
            MODE_EXP: begin
                if (base == 16'd0)
                    res = 32'd0;
                else if (sh >= 8'd32 || (|shifted[47:32]))
                    res = '1;
                else
                    res = shifted[31:0];
            end
            MODE_PROG: res = {7'd0, prod};
            default:   res = {16'd0, base};
        endcase
        return res;
    endfunction

    // configuration
    logic [15:0] r_base;
    logic [7:0]  r_limit;
    logic [1:0]  r_mode;

    // transaction context
    logic [1:0]    r_cmd;
    logic [31:0]   r_addr;
    logic [31:0]   r_now;
    logic          r_full;
    logic [CW-1:0] r_slot;
    logic [CW-1:0] r_loaded;

    // accumulators
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_best;
    logic          r_dup;

    // table and pipe
    t_entry        r_mem [MAX_PEERS];
    t_entry        r_q;
    logic          r_q_vld;
    logic [IW-1:0] r_q_idx;

    t_entry        r_a_ent;
    logic          r_a_vld;
    logic [IW-1:0] r_a_idx;
    logic [31:0]   r_a_tmo_old;
    logic [31:0]   r_a_tmo_new;
    logic [7:0]    r_a_newret;
    logic          r_a_active;
    logic          r_a_match;

    t_rsp r_out;
    logic r_out_vld;

    // stage a
    logic [7:0]  w_newret;
    logic [31:0] w_tmo_old;
    logic [31:0] w_tmo_new;

    // stage b
    logic [32:0] w_due_sum;
    logic        w_due;
    logic [32:0] w_dl_sum;
    logic [31:0] w_dl;
    logic        w_send;
    logic        w_inc;
    logic        w_dup_hit;
    logic        w_wr;
    t_entry      w_wr_ent;

    logic          w_adv;
    logic          w_out_free;
    logic          w_emit_send;
    logic          w_load_new;
    logic          w_we;
    logic [IW-1:0] w_wa;
    t_entry        w_wd;
    t_rsp          w_sum;
    t_rsp          w_snd;

    assign w_newret  = (r_q.retries == RETRY_MAX) ? r_q.retries : r_q.retries + 8'd1;
    assign w_tmo_old = f_backoff(r_base, r_mode, r_q.retries);
    assign w_tmo_new = f_backoff(r_base, r_mode, w_newret);

    // due when last_sent + timeout <= now, no wrap
    assign w_due_sum = {1'b0, r_a_ent.last_sent} + {1'b0, r_a_tmo_old};
    assign w_due     = (w_due_sum <= {1'b0, r_now});
    assign w_dl_sum  = {1'b0, r_now} + {1'b0, r_a_tmo_new};
    assign w_dl      = w_dl_sum[32] ? '1 : w_dl_sum[31:0];

    always_comb begin
        w_send    = 1'b0;
        w_inc     = 1'b0;
        w_dup_hit = 1'b0;
        w_wr      = 1'b0;
        w_wr_ent  = r_a_ent;
        case (r_cmd)
            CMD_TICK: begin
                w_inc  = r_a_active;
                w_send = r_a_active && w_due;
                w_wr   = w_send;
                w_wr_ent.last_sent = r_now;
                w_wr_ent.retries   = r_a_newret;
                w_wr_ent.replied   = 1'b0;
            end
            CMD_RESTART: begin
                w_inc = 1'b1;
                w_wr  = 1'b1;
                w_wr_ent.last_sent = '0;
                w_wr_ent.retries   = '0;
                w_wr_ent.replied   = 1'b0;
            end
            CMD_REPLY: begin
                w_inc     = !r_a_match && !r_a_ent.replied;
                w_dup_hit = r_a_match && r_a_ent.replied;
                w_wr      = r_a_match && !r_a_ent.replied;
                w_wr_ent.replied = 1'b1;
            end
            default: begin
                w_inc = r_a_active;
            end
        endcase
    end

    assign w_out_free  = !r_out_vld || i_rsp_rdy;
    // a send waiting on a full output register stalls the whole walk
    assign w_adv       = !(r_a_vld && w_send && !w_out_free);
    assign w_emit_send = r_a_vld && w_send && w_adv;

    assign o_stat.adv        = w_adv;
    assign o_stat.pipe_empty = !r_q_vld && !r_a_vld;
    assign o_stat.out_free   = w_out_free;
    assign o_loaded          = r_loaded;

    assign w_load_new = i_ctl.start && (i_command == CMD_LOAD) && (r_loaded < MAX_CNT);

    always_comb begin
        if (w_load_new) begin
            w_we = 1'b1;
            w_wa = r_loaded[IW-1:0];
            w_wd = '{addr: i_peer_addr, last_sent: 32'd0, retries: 8'd0, replied: 1'b0};
        end else begin
            w_we = r_a_vld && w_adv && w_wr;
            w_wa = r_a_idx;
            w_wd = w_wr_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we)
            r_mem[w_wa] <= w_wd;
        if (i_ctl.rd_en)
            r_q <= r_mem[i_rd_idx];
    end

    always_comb begin
        w_snd            = '0;
        w_snd.kind       = KIND_SEND;
        w_snd.peer_index = 4'(r_a_idx);
        w_snd.send_addr  = r_a_ent.addr;
    end

    always_comb begin
        w_sum               = '0;
        w_sum.last          = 1'b1;
        w_sum.pending_count = 5'(r_cnt);
        w_sum.all_done      = (r_cnt == '0);
        case (r_cmd)
            CMD_LOAD: begin
                w_sum.kind       = KIND_ACK;
                w_sum.peer_index = r_full ? 4'd0 : 4'(r_slot);
                w_sum.table_full = r_full;
            end
            CMD_RESTART: begin
                w_sum.kind = KIND_ACK;
            end
            CMD_TICK: begin
                w_sum.kind          = KIND_TICK;
                w_sum.next_deadline = r_best;
            end
            default: begin
                w_sum.kind            = KIND_REPLY;
                w_sum.duplicate_reply = r_dup;
            end
        endcase
    end

    // pipe payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q_idx     <= i_rd_idx;
            r_a_ent     <= r_q;
            r_a_idx     <= r_q_idx;
            r_a_tmo_old <= w_tmo_old;
            r_a_tmo_new <= w_tmo_new;
            r_a_newret  <= w_newret;
            r_a_active  <= !r_q.replied && (r_q.retries <= r_limit);
            r_a_match   <= (r_q.addr == r_addr);
        end
        if (i_ctl.start) begin
            r_cmd  <= i_command;
            r_addr <= i_peer_addr;
            r_now  <= i_now;
            r_slot <= r_loaded;
            r_full <= (i_command == CMD_LOAD) && (r_loaded == MAX_CNT);
        end
        if (w_emit_send)
            r_out <= w_snd;
        else if (i_ctl.sum_emit)
            r_out <= w_sum;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= 16'd60;
            r_limit   <= 8'd5;
            r_mode    <= MODE_LINEAR;
            r_loaded  <= '0;
            r_q_vld   <= 1'b0;
            r_a_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            r_cnt     <= '0;
            r_best    <= '1;
            r_dup     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE:  r_base  <= i_cfg_data;
                    CFG_LIMIT: r_limit <= i_cfg_data[7:0];
                    CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                    default:   ;
                endcase
            end
            if (w_load_new)
                r_loaded <= CW'(r_loaded + 1'b1);
            if (w_adv) begin
                r_q_vld <= i_ctl.rd_en;
                r_a_vld <= r_q_vld;
            end
            if (i_ctl.start) begin
                r_cnt  <= '0;
                r_best <= '1;
                r_dup  <= 1'b0;
            end else if (r_a_vld && w_adv) begin
                if (w_inc)
                    r_cnt <= CW'(r_cnt + 1'b1);
                if (w_send && (w_dl < r_best))
                    r_best <= w_dl;
                if (w_dup_hit)
                    r_dup <= 1'b1;
            end
            if (w_emit_send || i_ctl.sum_emit)
                r_out_vld <= 1'b1;
            else if (i_rsp_rdy)
                r_out_vld <= 1'b0;
        end
    end

    assign o_rsp_vld = r_out_vld;
    assign o_rsp     = r_out;

endmodule

### sv/peer_retransmit_scheduler.sv
// Peer retransmit scheduler: one transaction (load, restart, tick or reply) is handled at a
// time. After acceptance the peer table is read one entry per cycle, unless a send request
// is held off at the output, from a memory with one read and one write port. Each entry
// then passes through a two-stage evaluation: backoff timeouts first, then the due test,
// write-back and deadline minimum. The walk of a load includes the peer it adds. A tick
// emits one send request per resent peer and then a summary; every other command gives one
// result. The last result of each input has last set. Table contents need no clearing
// after reset: only loaded entries are ever read, and a load writes its entry in full.
// Configuration is written on i_cfg_we; the user must write it only while idle, as the
// block itself does not enforce this.
module peer_retransmit_scheduler #(
    parameter int MAX_PEERS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    prs_req_if.sink                           i_req,
    prs_rsp_if.source                         o_rsp,
    input  logic                              i_cfg_we,
    input  logic [prs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [prs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import prs_pkg::*;

    localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CW = $clog2(MAX_PEERS + 1);

    t_ctl          w_ctl;
    t_stat         w_stat;
    t_rsp          w_rsp;
    logic [CW-1:0] w_loaded;
    logic [IW-1:0] w_rd_idx;
    logic          w_req_rdy;
    logic          w_rsp_vld;

    prs_ctrl #(
        .MAX_PEERS (MAX_PEERS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req_vld (i_req.valid),
        .o_req_rdy (w_req_rdy),
        .i_stat    (w_stat),
        .i_loaded  (w_loaded),
        .o_ctl     (w_ctl),
        .o_rd_idx  (w_rd_idx)
    );

    prs_datapath #(
        .MAX_PEERS (MAX_PEERS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_command   (i_req.command),
        .i_peer_addr (i_req.peer_addr),
        .i_now       (i_req.now),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (w_ctl),
        .i_rd_idx    (w_rd_idx),
        .o_stat      (w_stat),
        .o_loaded    (w_loaded),
        .o_rsp_vld   (w_rsp_vld),
        .i_rsp_rdy   (o_rsp.ready),
        .o_rsp       (w_rsp)
    );

    assign i_req.ready = w_req_rdy;

    assign o_rsp.valid           = w_rsp_vld;
    assign o_rsp.kind            = w_rsp.kind;
    assign o_rsp.peer_index      = w_rsp.peer_index;
    assign o_rsp.send_addr       = w_rsp.send_addr;
    assign o_rsp.pending_count   = w_rsp.pending_count;
    assign o_rsp.next_deadline   = w_rsp.next_deadline;
    assign o_rsp.all_done        = w_rsp.all_done;
    assign o_rsp.duplicate_reply = w_rsp.duplicate_reply;
    assign o_rsp.table_full      = w_rsp.table_full;
    assign o_rsp.last            = w_rsp.last;

endmodule
